// ===== hw/rtl/mkd_pkg.sv =====
// Shared types, constants and the Morse lookup table for the key timing decoder.
`timescale 1ns / 1ps

package mkd_pkg;

	localparam int MAX_SYMBOLS_DEF = 6;
	localparam int TIME_W          = 32;
	localparam int THR_W           = 16;
	localparam int CHAR_W          = 7;
	localparam int CFG_INDEX_W     = 4;

	// Lookup keys are held at the widest buffer the parameter range allows.
	localparam int LUT_BITS_W = 8;
	localparam int LUT_CNT_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_DOT_MAX  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_DASH_MAX = CFG_INDEX_W'(1);

	localparam logic [THR_W-1:0] DOT_MAX_RESET  = THR_W'(250);
	localparam logic [THR_W-1:0] DASH_MAX_RESET = THR_W'(1000);

	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_SPACE   = 2'd1,
		KIND_UNKNOWN = 2'd2,
		KIND_ERASED  = 2'd3
	} kind_t;

	typedef struct packed {
		logic              key_level;
		logic              translate_level;
		logic [TIME_W-1:0] time_ms;
	} in_item_t;

	typedef struct packed {
		kind_t             result_kind;
		logic [CHAR_W-1:0] character;
	} out_item_t;

	typedef struct packed {
		logic [THR_W-1:0] dot_max_ms;
		logic [THR_W-1:0] dash_max_ms;
	} thresholds_t;

	// Symbol i of the pattern sits in bit i, a dash is a one. Stored bits above
	// the count are always zero, so count and bits together form the key.
	// Returns zero for a pattern that is not in the table.
	function automatic logic [CHAR_W-1:0] morse_lookup(
		input logic [LUT_CNT_W-1:0]  count,
		input logic [LUT_BITS_W-1:0] bits
	);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_NONE;
		unique case (count)
			4'd1: begin
				case (bits)
					8'd0: ch = 7'h45; // E
					8'd1: ch = 7'h54; // T
					default: ch = CHAR_NONE;
				endcase
			end
			4'd2: begin
				case (bits)
					8'd0: ch = 7'h49; // I
					8'd1: ch = 7'h4E; // N
					8'd2: ch = 7'h41; // A
					8'd3: ch = 7'h4D; // M
					default: ch = CHAR_NONE;
				endcase
			end
			4'd3: begin
				case (bits)
					8'd0: ch = 7'h53; // S
					8'd1: ch = 7'h44; // D
					8'd2: ch = 7'h52; // R
					8'd3: ch = 7'h47; // G
					8'd4: ch = 7'h55; // U
					8'd5: ch = 7'h4B; // K
					8'd6: ch = 7'h57; // W
					8'd7: ch = 7'h4F; // O
					default: ch = CHAR_NONE;
				endcase
			end
			4'd4: begin
				case (bits)
					8'd0:  ch = 7'h48; // H
					8'd1:  ch = 7'h42; // B
					8'd2:  ch = 7'h4C; // L
					8'd3:  ch = 7'h5A; // Z
					8'd4:  ch = 7'h46; // F
					8'd5:  ch = 7'h43; // C
					8'd6:  ch = 7'h50; // P
					8'd8:  ch = 7'h56; // V
					8'd9:  ch = 7'h58; // X
					8'd11: ch = 7'h51; // Q
					8'd13: ch = 7'h59; // Y
					8'd14: ch = 7'h4A; // J
					default: ch = CHAR_NONE;
				endcase
			end
			4'd5: begin
				case (bits)
					8'd0:  ch = 7'h35; // 5
					8'd1:  ch = 7'h36; // 6
					8'd3:  ch = 7'h37; // 7
					8'd7:  ch = 7'h38; // 8
					8'd15: ch = 7'h39; // 9
					8'd16: ch = 7'h34; // 4
					8'd24: ch = 7'h33; // 3
					8'd28: ch = 7'h32; // 2
					8'd30: ch = 7'h31; // 1
					8'd31: ch = 7'h30; // 0
					default: ch = CHAR_NONE;
				endcase
			end
			4'd6: begin
				case (bits)
					8'd0: ch = 7'h3F; // ?
					default: ch = CHAR_NONE;
				endcase
			end
			default: ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

// ===== hw/rtl/morse_key_timing_decoder_core.sv =====
// Top level of the Morse key timing decoder: beat registers and configuration.
`timescale 1ns / 1ps

// Takes one poll of key, translate button and millisecond clock per beat and
// sustains one poll per cycle while the downstream side does not stall. A
// poll is captured in an input register, is decoded against the symbol
// buffer once the result register is free and, if it yields a character,
// space, unknown-code or erase report, leaves through a result register.
// Key releases add a dot or dash by hold time, nothing past the dash limit,
// and give no result. Input stall rises only while the input register is
// full and the result register is held by a stalled downstream side.
// Thresholds are written through the configuration channel, which is always
// ready; indexes past the dash limit are ignored.
module morse_key_timing_decoder_core import mkd_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]       cfg_data
);

	logic        item_valid_s1;
	in_item_t    item_s1;
	logic        advance;
	logic        res_valid;
	out_item_t   res;
	logic        out_valid_q;
	out_item_t   out_data_q;
	thresholds_t thr_q;

	// The poll in the input register moves on once the result register is free.
	assign advance   = item_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = item_valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	mkd_decode #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.thr      (thr_q),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
			thr_q         <= '{dot_max_ms: DOT_MAX_RESET, dash_max_ms: DASH_MAX_RESET};
		end else begin
			if (in_valid && !in_stall) begin
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end

			if (advance) begin
				out_valid_q <= res_valid;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DOT_MAX:  thr_q.dot_max_ms  <= cfg_data;
					REG_DASH_MAX: thr_q.dash_max_ms <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule

// ===== hw/rtl/mkd_decode.sv =====
// Symbol buffer, key edge timing and translate/erase decision for one poll.
`timescale 1ns / 1ps

module mkd_decode import mkd_pkg::*; #(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  in_item_t    item,
	input  thresholds_t thr,
	output logic        res_valid,
	output out_item_t   res
);

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int IDX_W = $clog2(MAX_SYMBOLS);

	logic [MAX_SYMBOLS-1:0] bits_q, bits_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic                   ovf_q, ovf_d;
	logic                   prev_key_q, prev_key_d;
	logic [TIME_W-1:0]      press_q, press_d;

	logic [TIME_W-1:0] hold;
	logic              fits_dot;
	logic              fits_dash;
	logic [CHAR_W-1:0] lut_ch;
	logic [CHAR_W-1:0] dec_ch;

	assign hold      = item.time_ms - press_q;
	assign fits_dot  = (hold <= TIME_W'(thr.dot_max_ms));
	assign fits_dash = (hold <= TIME_W'(thr.dash_max_ms));
	assign lut_ch    = morse_lookup(LUT_CNT_W'(count_q), LUT_BITS_W'(bits_q));
	assign dec_ch    = ovf_q ? CHAR_NONE : lut_ch;

	always_comb begin
		bits_d     = bits_q;
		count_d    = count_q;
		ovf_d      = ovf_q;
		prev_key_d = prev_key_q;
		press_d    = press_q;
		res_valid  = 1'b0;
		res        = '{result_kind: KIND_CHAR, character: CHAR_NONE};

		if (item.translate_level && !item.key_level) begin
			bits_d    = '0;
			count_d   = '0;
			ovf_d     = 1'b0;
			res_valid = 1'b1;
			res       = '{result_kind: KIND_ERASED, character: CHAR_NONE};
		end else if (item.translate_level) begin
			res_valid = 1'b1;
			if (count_q == '0 && !ovf_q) begin
				res = '{result_kind: KIND_SPACE, character: CHAR_SPACE};
			end else begin
				res.result_kind = (dec_ch != CHAR_NONE) ? KIND_CHAR : KIND_UNKNOWN;
				res.character   = dec_ch;
				bits_d          = '0;
				count_d         = '0;
				ovf_d           = 1'b0;
			end
		end else if (item.key_level != prev_key_q) begin
			prev_key_d = item.key_level;
			if (!item.key_level) begin
				press_d = item.time_ms;
			end else if (fits_dot || fits_dash) begin
				// The dot limit is checked first; a hold past both limits adds nothing.
				if (count_q < CNT_W'(MAX_SYMBOLS)) begin
					bits_d[count_q[IDX_W-1:0]] = !fits_dot;
					count_d = count_q + CNT_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q     <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			prev_key_q <= 1'b1;
			press_q    <= '0;
		end else if (fire) begin
			bits_q     <= bits_d;
			count_q    <= count_d;
			ovf_q      <= ovf_d;
			prev_key_q <= prev_key_d;
			press_q    <= press_d;
		end
	end

endmodule

// ===== verif/morse_decode_checker.sv =====
// Checker for the Morse key timing decoder: predicts each poll's report and compares results.
`timescale 1ns / 1ps

module morse_decode_checker import mkd_pkg::*; #(
	parameter int MAX_SYMS = MAX_SYMBOLS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  in_item_t               in_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  out_item_t              out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]       cfg_data,
	output int                     n_errors,
	output int                     n_pending
);

	string mc_pattern [37] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
		"----.", "-----", "......"
	};
	string mc_letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890?";

	logic [THR_W-1:0] dot_lim;
	logic [THR_W-1:0] dash_lim;
	logic [7:0]       sym_bits;
	int               sym_cnt;
	logic             ovf;
	logic             prev_key;
	logic [31:0]      press_ms;

	out_item_t expected_reports [$];
	int        err_cnt  = 0;
	int        pend_cnt = 0;

	assign n_errors  = err_cnt;
	assign n_pending = pend_cnt;

	function automatic void clear_symbols();
		sym_bits = '0;
		sym_cnt  = 0;
		ovf      = 1'b0;
	endfunction

	function automatic void add_symbol(input logic is_dash);
		if (sym_cnt < MAX_SYMS) begin
			sym_bits[sym_cnt] = is_dash;
			sym_cnt++;
		end else begin
			ovf = 1'b1;
		end
	endfunction

	// Symbol n of a pattern is bit n of the buffer, a dash being a one.
	function automatic logic [CHAR_W-1:0] morse_char();
		string p;
		logic  same;
		byte   ch8;
		for (int e = 0; e < 37; e++) begin
			p = mc_pattern[e];
			if (p.len() != sym_cnt)
				continue;
			same = 1'b1;
			for (int n = 0; n < p.len(); n++) begin
				if ((p[n] == "-") != sym_bits[n])
					same = 1'b0;
			end
			if (same) begin
				ch8 = mc_letters[e];
				return ch8[CHAR_W-1:0];
			end
		end
		return CHAR_NONE;
	endfunction

	function automatic logic predict_poll(input in_item_t p, output out_item_t r);
		logic [31:0]       hold;
		logic [CHAR_W-1:0] ch;
		r.result_kind = KIND_CHAR;
		r.character   = CHAR_NONE;
		// Translate with the key held down erases, ahead of everything else.
		if (p.translate_level && !p.key_level) begin
			clear_symbols();
			r.result_kind = KIND_ERASED;
			return 1'b1;
		end
		if (p.translate_level) begin
			if (sym_cnt == 0 && !ovf) begin
				r.result_kind = KIND_SPACE;
				r.character   = CHAR_SPACE;
			end else begin
				ch = ovf ? CHAR_NONE : morse_char();
				r.result_kind = (ch != CHAR_NONE) ? KIND_CHAR : KIND_UNKNOWN;
				r.character   = ch;
				clear_symbols();
			end
			return 1'b1;
		end
		if (p.key_level != prev_key) begin
			if (!p.key_level) begin
				press_ms = p.time_ms;
			end else begin
				hold = p.time_ms - press_ms;
				if (hold <= {16'd0, dot_lim})
					add_symbol(1'b0);
				else if (hold <= {16'd0, dash_lim})
					add_symbol(1'b1);
			end
			prev_key = p.key_level;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			dot_lim  = DOT_MAX_RESET;
			dash_lim = DASH_MAX_RESET;
			clear_symbols();
			prev_key = 1'b1;
			press_ms = '0;
			expected_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DOT_MAX: dot_lim = cfg_data;
					REG_DASH_MAX: dash_lim = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result kind=%0d char=%h", $time,
						out_data.result_kind, out_data.character);
					err_cnt++;
				end else begin
					want = expected_reports.pop_front();
					if (out_data.result_kind !== want.result_kind) begin
						$display("%0t: result_kind expected %0d actual %0d", $time,
							want.result_kind, out_data.result_kind);
						err_cnt++;
					end
					if (out_data.character !== want.character) begin
						$display("%0t: character expected %h actual %h", $time,
							want.character, out_data.character);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (predict_poll(in_data, got))
					expected_reports.push_back(got);
			end
		end
		pend_cnt = expected_reports.size();
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the Morse key timing decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import mkd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int POLLS_PER_BLOCK = 225;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0]       cfg_data  = '0;

	int          n_errors;
	int          n_pending;
	int unsigned send_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned dot_now   = 32'(DOT_MAX_RESET);
	int unsigned dash_now  = 32'(DASH_MAX_RESET);
	int unsigned polls_sent = 0;
	int          idle_cycles = 0;
	logic [31:0] clock_ms = '0;

	int unsigned dot_tab  [8] = '{250, 0, 65535, 0, 500, 120, 65535, 100};
	int unsigned dash_tab [8] = '{1000, 0, 65535, 65535, 100, 600, 0, 2000};
	int unsigned send_tab [4] = '{0, 64, 0, 11};
	int unsigned stall_tab[4] = '{0, 0, 64, 11};

	always #5 clk = ~clk;

	morse_key_timing_decoder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	morse_decode_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.n_errors(n_errors), .n_pending(n_pending)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_poll(input logic key, input logic tr, input logic [31:0] t);
		in_item_t it;
		it.key_level       = key;
		it.translate_level = tr;
		it.time_ms         = t;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		polls_sent++;
	endtask

	// One key press and release, the release following the press by hold ms.
	task automatic tap(input logic [31:0] hold);
		send_poll(1'b0, 1'b0, clock_ms);
		clock_ms += hold;
		send_poll(1'b1, 1'b0, clock_ms);
		clock_ms += $urandom_range(1, 400);
	endtask

	// Drains every expected report, then leaves room for polls that give none.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [THR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_DOT_MAX)
			dot_now = 32'(val);
		else if (idx == REG_DASH_MAX)
			dash_now = 32'(val);
	endtask

	function automatic logic [31:0] pick_hold(input logic want_dash);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return $urandom();
		if (r == 1)
			return dash_now + 1 + $urandom_range(0, 3000);
		if (!want_dash || dash_now <= dot_now)
			return (r == 2) ? dot_now : $urandom_range(0, dot_now);
		if (r == 2)
			return dash_now;
		if (r == 3)
			return dot_now + 1;
		return $urandom_range(dot_now + 1, dash_now);
	endfunction

	task automatic random_burst();
		int unsigned r;
		int unsigned n;
		int unsigned k;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			// A well-formed character, now and then running past the buffer.
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 8);
			for (int i = 0; i < n; i++) begin
				tap(pick_hold(1'($urandom_range(0, 1))));
				if ($urandom_range(0, 19) == 0)
					send_poll(1'b1, 1'b0, clock_ms);
			end
			k = $urandom_range(0, 19);
			if (k == 0) begin
				send_poll(1'b0, 1'b1, clock_ms);
			end else if (k != 1) begin
				send_poll(1'b1, 1'b1, clock_ms);
				if ($urandom_range(0, 9) == 0)
					send_poll(1'b1, 1'b1, clock_ms + 1);
			end
		end else if (r < 88) begin
			send_poll(1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0),
				clock_ms + $urandom_range(0, 2000));
			clock_ms += $urandom_range(0, 3000);
		end else begin
			send_poll(1'($urandom_range(0, 1)), 1'b1, clock_ms);
		end
		if ($urandom_range(0, 99) < 3)
			clock_ms = $urandom();
	endtask

	initial begin
		int unsigned block_start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: space, erase, boundaries of both limits, clock wrap, six dots.
		send_poll(1'b1, 1'b1, 32'd0);
		send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
		clock_ms = 32'd5000;
		tap(32'd250);
		tap(32'd1001);
		tap(32'd1000);
		send_poll(1'b1, 1'b1, clock_ms);
		clock_ms = 32'hFFFF_FF80;
		tap(32'd256);
		send_poll(1'b1, 1'b1, clock_ms);
		for (int i = 0; i < 6; i++)
			tap(32'd100);
		send_poll(1'b1, 1'b1, clock_ms);

		for (int blk = 0; blk < 8; blk++) begin
			settle();
			if (blk == 5) begin
				dot_tab[5]  = $urandom_range(20, 400);
				dash_tab[5] = dot_tab[5] + $urandom_range(1, 1500);
			end
			write_reg(REG_DOT_MAX, THR_W'(dot_tab[blk]));
			write_reg(REG_DASH_MAX, THR_W'(dash_tab[blk]));
			// An index past the last register must leave both limits alone.
			write_reg(CFG_INDEX_W'(2 + (blk * 5) % 14), THR_W'($urandom()));
			cfg_valid <= 1'b0;
			send_pct  = send_tab[blk % 4];
			stall_pct = stall_tab[blk % 4];
			block_start = polls_sent;
			while (polls_sent - block_start < POLLS_PER_BLOCK)
				random_burst();
		end

		settle();
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_decode.sv
hw/rtl/morse_key_timing_decoder_core.sv
verif/morse_decode_checker.sv
verif/tb.sv
